// File: src/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// Shared constants, types and state codes for the point-gravity stepper.
// ----------------------------------------------------------------------------
package isg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int STR_W     = 28;
    localparam int OFF_W     = 33;
    localparam int SQ_W      = 67;
    localparam int ROOT_W    = 35;
    localparam int CUBE_W    = 105;
    localparam int NUM_W     = 128;
    localparam int DIV_CNT_W = 7;
    localparam int SHIFT_AMT = 3 * FRAC_BITS - 8;

    localparam logic [2:0] REG_SOURCE_X   = 3'd0;
    localparam logic [2:0] REG_SOURCE_Y   = 3'd1;
    localparam logic [2:0] REG_STRENGTH   = 3'd2;
    localparam logic [2:0] REG_START_PX   = 3'd3;
    localparam logic [2:0] REG_START_PY   = 3'd4;
    localparam logic [2:0] REG_START_VX   = 3'd5;
    localparam logic [2:0] REG_START_VY   = 3'd6;

    localparam logic [DATA_W-1:0] RST_SOURCE_X = 32'd52428800;
    localparam logic [DATA_W-1:0] RST_SOURCE_Y = 32'd32768000;
    localparam logic [STR_W-1:0]  RST_STRENGTH = 28'd1792000;
    localparam logic [DATA_W-1:0] RST_START_PX = 32'd39321600;
    localparam logic [DATA_W-1:0] RST_START_PY = 32'd45875200;
    localparam logic [DATA_W-1:0] RST_START_VX = 32'd262144;
    localparam logic [DATA_W-1:0] RST_START_VY = 32'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_CUBE,
        ST_NUMX,
        ST_DIVX,
        ST_NUMY,
        ST_DIVY,
        ST_SUM,
        ST_OUT
    } isg_state_t;

    // clamp a two's complement sum to 32 bits, returns {clamped, value}
    function automatic logic [DATA_W:0] isg_sat(input logic [DATA_W+1:0] v);
        logic [DATA_W:0] res;
        res = {1'b0, v[DATA_W-1:0]};
        if (!(v[DATA_W+1:DATA_W-1] inside {3'b000, 3'b111}))
            res = v[DATA_W+1] ? {2'b11, {(DATA_W-1){1'b0}}}
                              : {2'b10, {(DATA_W-1){1'b1}}};
        return res;
    endfunction

endpackage

// File: src/isg_mul.sv
// ----------------------------------------------------------------------------
// isg_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module isg_mul
    import isg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CUBE_W-1:0]   a,
    input  logic [ROOT_W-1:0]   b,
    output logic                busy,
    output logic [CUBE_W-1:0]   prod
);

    logic [CUBE_W-1:0] acc_reg, acc_next;
    logic [CUBE_W-1:0] mcand_reg, mcand_next;
    logic [ROOT_W-1:0] mplier_reg, mplier_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            cnt_next    = 6'(ROOT_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[CUBE_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[ROOT_W-1:1]};
            cnt_next    = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

// File: src/isg_sqrt.sv
// ----------------------------------------------------------------------------
// isg_sqrt
// Restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module isg_sqrt
    import isg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    // radicand padded to an even width so two bits come in per step
    localparam int RAD_W = 2 * ROOT_W;

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] q_reg, q_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] shifted;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {q_reg, 2'b01};
        if (start)
        begin
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next = shifted - trial;
                q_next   = {q_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign root = q_reg;

endmodule

// File: src/isg_div.sv
// ----------------------------------------------------------------------------
// isg_div
// Restoring divider, one quotient bit per cycle, quotient held at 2^32.
// ----------------------------------------------------------------------------
module isg_div
    import isg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [CUBE_W-1:0]  den,
    output logic               busy,
    output logic [DATA_W:0]    quot
);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [CUBE_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [DIV_CNT_W:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [CUBE_W:0]   shifted;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[CUBE_W-1:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = (DIV_CNT_W+1)'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (shifted >= {1'b0, den})
            begin
                rem_next = shifted - {1'b0, den};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - (DIV_CNT_W+1)'(1);
            if (cnt_reg == (DIV_CNT_W+1)'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = (q_reg > NUM_W'(64'h1_0000_0000)) ? {1'b1, {DATA_W{1'b0}}}
                                                     : q_reg[DATA_W:0];

endmodule

// File: src/inverse_square_gravity_step_core.sv
// ----------------------------------------------------------------------------
// inverse_square_gravity_step_core
// Semi-implicit Euler step of one particle pulled by a fixed point source.
// ----------------------------------------------------------------------------
// Usage: write the source and start registers through the cfg channel
// (cfg_index 0..6, cfg_data) while no beat is in flight. Each input beat on
// in_valid/in_ready carries restart. restart=1 loads the start values;
// restart=0 runs one gravity tick. Exactly one output beat follows each
// input beat with the new position, velocity and the saturated flag.
// A restart beat goes straight to the output state, where out_valid is
// registered once the output register is free. A tick runs the two squares
// and the two cube products on one shift-add multiplier, the square root,
// two numerator products and two divisions, then the x velocity sum and, in
// the output state, the position sums; when the particle sits on the source
// the cube, numerator and division steps are skipped. One beat is in work
// at a time; in_ready is high while the datapath is idle, so the next input
// beat can be taken in the cycle in which out_valid rises.
// Reset loads every register with its reset value and the particle state
// with the start values. A result waiting on out_ready holds in the output
// register; the next beat still runs, then waits with in_ready low.
// ----------------------------------------------------------------------------
module inverse_square_gravity_step_core
    import isg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_pos_x,
    output logic [DATA_W-1:0] out_pos_y,
    output logic [DATA_W-1:0] out_vel_x,
    output logic [DATA_W-1:0] out_vel_y,
    output logic              saturated,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    isg_state_t state_reg, state_next;

    logic [DATA_W-1:0] src_x_reg, src_y_reg, spx_reg, spy_reg, svx_reg, svy_reg;
    logic [STR_W-1:0]  str_reg;
    logic [DATA_W-1:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [DATA_W-1:0] px_next, py_next, vx_next, vy_next;
    logic              sat_reg, sat_next;
    logic              ov_reg;
    logic              phase_reg, phase_next;
    logic              go_reg, go_next;
    logic              pos_pend_reg;
    logic [DATA_W-1:0] opx_reg, opy_reg, ovx_reg, ovy_reg;
    logic              osat_reg;

    logic [OFF_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [ROOT_W-1:0] r_reg, r_next;
    logic [CUBE_W-1:0] r3_reg, r3_next;
    logic [NUM_W-1:0]  n_reg, n_next;
    logic [DATA_W+1:0] ax_reg, ax_next;

    logic              in_fire, out_fire, out_load;
    logic              mul_start, sqrt_start, div_start;
    logic              mul_busy, sqrt_busy, div_busy;
    logic [CUBE_W-1:0] mul_a;
    logic [ROOT_W-1:0] mul_b;
    logic [CUBE_W-1:0] prod;
    logic [ROOT_W-1:0] root;
    logic [DATA_W:0]   quot;
    logic [OFF_W-1:0]  ox, oy, mag_x, mag_y, cur_off;
    logic [DATA_W+1:0] sgn_acc;
    logic [DATA_W+1:0] vsum_x, vsum_y, psum_x, psum_y;
    logic [DATA_W:0]   vx_sat, vy_sat, px_sat, py_sat;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || out_fire);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign cfg_ready = 1'b1;

    assign ox    = {src_x_reg[DATA_W-1], src_x_reg} - {px_reg[DATA_W-1], px_reg};
    assign oy    = {src_y_reg[DATA_W-1], src_y_reg} - {py_reg[DATA_W-1], py_reg};
    assign mag_x = dx_reg[OFF_W-1] ? -dx_reg : dx_reg;
    assign mag_y = dy_reg[OFF_W-1] ? -dy_reg : dy_reg;
    assign cur_off = (state_reg == ST_DIVY || state_reg == ST_NUMY) ? dy_reg : dx_reg;
    // one extra bit so a pull held at 2^32 keeps its sign
    assign sgn_acc = cur_off[OFF_W-1] ? -{1'b0, quot} : {1'b0, quot};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ:
            begin
                mul_a = CUBE_W'(phase_reg ? mag_y : mag_x);
                mul_b = ROOT_W'(phase_reg ? mag_y : mag_x);
            end
            ST_CUBE:
            begin
                mul_a = phase_reg ? r3_reg : CUBE_W'(r_reg);
                mul_b = r_reg;
            end
            ST_NUMX:
            begin
                mul_a = CUBE_W'(mag_x);
                mul_b = ROOT_W'(str_reg);
            end
            ST_NUMY:
            begin
                mul_a = CUBE_W'(mag_y);
                mul_b = ROOT_W'(str_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    isg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (prod)
    );

    isg_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    isg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (n_reg),
        .den   (r3_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    // next state; go_reg marks that the unit of this state was kicked off
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = restart ? ST_OUT : ST_SQ;
            ST_SQ:
                if (go_reg && !mul_busy && phase_reg)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (go_reg && !sqrt_busy)
                    state_next = (root == '0) ? ST_SUM : ST_CUBE;
            ST_CUBE:
                if (go_reg && !mul_busy && phase_reg)
                    state_next = ST_NUMX;
            ST_NUMX:
                if (go_reg && !mul_busy)
                    state_next = ST_DIVX;
            ST_DIVX:
                if (go_reg && !div_busy)
                    state_next = ST_NUMY;
            ST_NUMY:
                if (go_reg && !mul_busy)
                    state_next = ST_DIVY;
            ST_DIVY:
                if (go_reg && !div_busy)
                    state_next = ST_SUM;
            ST_SUM:
                state_next = ST_OUT;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign vsum_x = {{2{vx_reg[DATA_W-1]}}, vx_reg} + ax_reg;
    assign vsum_y = {{2{vy_reg[DATA_W-1]}}, vy_reg} + sgn_acc;
    assign psum_x = {{2{px_reg[DATA_W-1]}}, px_reg} + {{2{vx_reg[DATA_W-1]}}, vx_reg};
    assign psum_y = {{2{py_reg[DATA_W-1]}}, py_reg} + {{2{vy_reg[DATA_W-1]}}, vy_reg};
    assign vx_sat = isg_sat(vsum_x);
    assign vy_sat = isg_sat(vsum_y);
    assign px_sat = isg_sat(psum_x);
    assign py_sat = isg_sat(psum_y);

    // datapath control and results
    always_comb
    begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        go_next    = go_reg;
        phase_next = phase_reg;
        sq_next    = sq_reg;
        r_next     = r_reg;
        r3_next    = r3_reg;
        n_next     = n_reg;
        ax_next    = ax_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        sat_next   = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                go_next    = 1'b0;
                phase_next = 1'b0;
                ax_next    = '0;
                if (in_fire)
                    sat_next = 1'b0;
                if (in_fire && restart)
                begin
                    px_next  = spx_reg;
                    py_next  = spy_reg;
                    vx_next  = svx_reg;
                    vy_next  = svy_reg;
                end
            end
            ST_SQ:
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (!mul_busy)
                begin
                    if (!phase_reg)
                    begin
                        sq_next    = SQ_W'(prod);
                        phase_next = 1'b1;
                        go_next    = 1'b0;
                    end
                    else
                    begin
                        sq_next    = sq_reg + SQ_W'(prod);
                        phase_next = 1'b0;
                        go_next    = 1'b0;
                    end
                end
            ST_SQRT:
                if (!go_reg)
                begin
                    sqrt_start = 1'b1;
                    go_next    = 1'b1;
                end
                else if (!sqrt_busy)
                begin
                    r_next  = root;
                    go_next = 1'b0;
                end
            ST_CUBE:
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (!mul_busy)
                begin
                    r3_next    = prod;
                    phase_next = !phase_reg;
                    go_next    = 1'b0;
                end
            ST_NUMX, ST_NUMY:
                if (!go_reg)
                begin
                    mul_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (!mul_busy)
                begin
                    n_next  = NUM_W'(prod) << SHIFT_AMT;
                    go_next = 1'b0;
                end
            ST_DIVX:
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (!div_busy)
                begin
                    ax_next = sgn_acc;
                    go_next = 1'b0;
                end
            ST_DIVY:
                if (!go_reg)
                begin
                    div_start = 1'b1;
                    go_next   = 1'b1;
                end
                else if (!div_busy)
                begin
                    // y acceleration folds straight into the velocity sum
                    vy_next  = vy_sat[DATA_W-1:0];
                    sat_next = sat_reg | vy_sat[DATA_W];
                    go_next  = 1'b0;
                end
            ST_SUM:
            begin
                // zero distance skipped the divisions, ax is zero and vy unchanged
                vx_next  = vx_sat[DATA_W-1:0];
                sat_next = sat_reg | vx_sat[DATA_W];
            end
            ST_OUT:
            begin
                go_next = 1'b0;
                // the position sum must use the new velocity, so it runs here
                if (pos_pend_reg)
                begin
                    px_next  = px_sat[DATA_W-1:0];
                    py_next  = py_sat[DATA_W-1:0];
                    sat_next = sat_reg | px_sat[DATA_W] | py_sat[DATA_W];
                end
            end
            default:
            begin
                go_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            phase_reg    <= 1'b0;
            ov_reg       <= 1'b0;
            pos_pend_reg <= 1'b0;
            src_x_reg    <= RST_SOURCE_X;
            src_y_reg    <= RST_SOURCE_Y;
            str_reg      <= RST_STRENGTH;
            spx_reg      <= RST_START_PX;
            spy_reg      <= RST_START_PY;
            svx_reg      <= RST_START_VX;
            svy_reg      <= RST_START_VY;
            px_reg       <= RST_START_PX;
            py_reg       <= RST_START_PY;
            vx_reg       <= RST_START_VX;
            vy_reg       <= RST_START_VY;
            sat_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            phase_reg <= phase_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            sat_reg   <= sat_next;
            pos_pend_reg <= (state_reg == ST_SUM);
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_fire)
                ov_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_X: src_x_reg <= cfg_data;
                    REG_SOURCE_Y: src_y_reg <= cfg_data;
                    REG_STRENGTH: str_reg   <= cfg_data[STR_W-1:0];
                    REG_START_PX: spx_reg   <= cfg_data;
                    REG_START_PY: spy_reg   <= cfg_data;
                    REG_START_VX: svx_reg   <= cfg_data;
                    REG_START_VY: svy_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        r_reg  <= r_next;
        r3_reg <= r3_next;
        n_reg  <= n_next;
        ax_reg <= ax_next;
        if (in_fire)
        begin
            dx_reg <= ox;
            dy_reg <= oy;
        end
        // output register parts the result from the particle state
        if (out_load)
        begin
            opx_reg  <= px_next;
            opy_reg  <= py_next;
            ovx_reg  <= vx_next;
            ovy_reg  <= vy_next;
            osat_reg <= sat_next;
        end
    end

    assign out_pos_x = opx_reg;
    assign out_pos_y = opy_reg;
    assign out_vel_x = ovx_reg;
    assign out_vel_y = ovy_reg;
    assign saturated = osat_reg;

endmodule

// File: dv/isg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isg_checker
// Watches the cfg, input and output channels of the gravity stepper, keeps its
// own copy of registers and particle state, predicts each result beat and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module isg_checker
    import isg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              restart,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] out_pos_x,
    input  logic [DATA_W-1:0] out_pos_y,
    input  logic [DATA_W-1:0] out_vel_x,
    input  logic [DATA_W-1:0] out_vel_y,
    input  logic              saturated,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    output int                fail_count,
    output int                pending,
    output int                results_seen,
    output int                sat_seen,
    output int                restarts_seen
);

    typedef struct {
        logic [DATA_W-1:0] pos_x;
        logic [DATA_W-1:0] pos_y;
        logic [DATA_W-1:0] vel_x;
        logic [DATA_W-1:0] vel_y;
        logic              sat;
    } motion_t;

    motion_t           motion_q[$];
    logic [DATA_W-1:0] src_x, src_y, st_px, st_py, st_vx, st_vy;
    logic [STR_W-1:0]  pull;
    logic [DATA_W-1:0] p_x, p_y, v_x, v_y;
    int                fails, n_res, n_sat, n_rst;

    function automatic logic signed [63:0] sx64(input logic [DATA_W-1:0] v);
        return {{32{v[DATA_W-1]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] clamp32(input logic signed [63:0] v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 34; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (v >= t * t)
                r = t;
        end
        return r;
    endfunction

    // pull along one axis, truncated toward zero, magnitude held at 2^32
    function automatic logic signed [63:0] pull_axis(input logic signed [63:0] off,
                                                     input logic [127:0] r,
                                                     input logic [127:0] r3);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (off < 0) ? -off : off;
        if (r == 0 || mag == 0)
            return 64'sd0;
        q = ((mag * pull) << SHIFT_AMT) / r3;
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        return (off < 0) ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
    endfunction

    function automatic motion_t advance(input logic do_restart);
        motion_t          m;
        bit               hit;
        logic signed [63:0] dx, dy;
        logic [127:0]     ax, ay, r, r3;
        hit = 1'b0;
        if (do_restart) begin
            p_x = st_px;
            p_y = st_py;
            v_x = st_vx;
            v_y = st_vy;
        end else begin
            dx = sx64(src_x) - sx64(p_x);
            dy = sx64(src_y) - sx64(p_y);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            r  = int_sqrt(ax * ax + ay * ay);
            r3 = r * r * r;
            v_x = clamp32(sx64(v_x) + pull_axis(dx, r, r3), hit);
            v_y = clamp32(sx64(v_y) + pull_axis(dy, r, r3), hit);
            p_x = clamp32(sx64(p_x) + sx64(v_x), hit);
            p_y = clamp32(sx64(p_y) + sx64(v_y), hit);
        end
        m.pos_x = p_x;
        m.pos_y = p_y;
        m.vel_x = v_x;
        m.vel_y = v_y;
        m.sat   = hit;
        return m;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        motion_t m;
        if (!rst_n) begin
            src_x = RST_SOURCE_X;
            src_y = RST_SOURCE_Y;
            pull  = RST_STRENGTH;
            st_px = RST_START_PX;
            st_py = RST_START_PY;
            st_vx = RST_START_VX;
            st_vy = RST_START_VY;
            p_x = st_px;
            p_y = st_py;
            v_x = st_vx;
            v_y = st_vy;
            motion_q.delete();
            fails = 0;
            n_res = 0;
            n_sat = 0;
            n_rst = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SOURCE_X: src_x = cfg_data;
                    REG_SOURCE_Y: src_y = cfg_data;
                    REG_STRENGTH: pull  = cfg_data[STR_W-1:0];
                    REG_START_PX: st_px = cfg_data;
                    REG_START_PY: st_py = cfg_data;
                    REG_START_VX: st_vx = cfg_data;
                    REG_START_VY: st_vy = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                n_res++;
                if (saturated)
                    n_sat++;
                if (motion_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end else begin
                    m = motion_q.pop_front();
                    if (m.pos_x !== out_pos_x || m.pos_y !== out_pos_y ||
                        m.vel_x !== out_vel_x || m.vel_y !== out_vel_y ||
                        m.sat !== saturated) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: result %0d mismatch exp pos %h %h vel %h %h sat %b",
                                      " got pos %h %h vel %h %h sat %b"}, $realtime, n_res,
                                     m.pos_x, m.pos_y, m.vel_x, m.vel_y, m.sat,
                                     out_pos_x, out_pos_y, out_vel_x, out_vel_y, saturated);
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (restart)
                    n_rst++;
                motion_q.push_back(advance(restart));
            end
        end
        fail_count    <= fails;
        pending       <= motion_q.size();
        results_seen  <= n_res;
        sat_seen      <= n_sat;
        restarts_seen <= n_rst;
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the point-gravity stepper: directed corner setups (extreme
// registers, zero distance, huge pull, overflow) followed by random register
// setups driving runs of ticks with occasional restarts, under random gaps
// and receiver stalls. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import isg_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 780;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              restart;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
    logic              saturated;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [DATA_W-1:0] cfg_data;
    int                fail_count, pending, results_seen, sat_seen, restarts_seen;
    int                idle_cycles;
    int                cfg_writes;
    bit                long_stall_done;

    inverse_square_gravity_step_core DUT (.*);

    isg_checker u_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---- receiver: changing stall pattern plus one long hold-off
    initial begin
        int cnt;
        int mode;
        cnt = 0;
        mode = 0;
        out_ready = 1'b0;
        long_stall_done = 1'b0;
        forever begin
            @(negedge clk);
            cnt++;
            if (!long_stall_done && results_seen >= 300) begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
                long_stall_done = 1'b1;
            end else begin
                if (cnt % 97 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ((cnt % 7) >= 3);
                endcase
            end
        end
    end

    // ---- watchdog on cycles with no beat on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end else begin
            idle_cycles <= 0;
        end
    end

    task automatic send_item(input logic rs);
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_gap();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_setup(input logic [31:0] sx, input logic [31:0] sy,
                              input logic [31:0] st, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] vx,
                              input logic [31:0] vy);
        drain();
        write_reg(REG_SOURCE_X, sx);
        write_reg(REG_SOURCE_Y, sy);
        write_reg(REG_STRENGTH, st);
        write_reg(REG_START_PX, px);
        write_reg(REG_START_PY, py);
        write_reg(REG_START_VX, vx);
        write_reg(REG_START_VY, vy);
    endtask

    // position-like value: mostly near the origin, sometimes extreme or wild
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'd0;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_strength();
        case ($urandom_range(0, 5))
            0: return 32'h0FFF_FFFF;
            1: return 32'd0;
            2: return $urandom();   // upper bits dropped by the block
            default: return $urandom_range(0, 32'h0040_0000);
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        logic [31:0] sx, sy;
        in_valid  = 1'b0;
        restart   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_X;
        cfg_data  = '0;
        cfg_writes = 0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset setup: plain orbit ticks, then a restart
        send_item(1'b0);
        send_item(1'b0);
        send_gap();
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);

        // extremes everywhere: overflow of velocity and position
        load_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h0FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // particle sitting on the source: no pull
        load_setup(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0100, 32'h0001_0000,
                   32'hFFFF_0000, 32'd0, 32'd0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // one raw step from the source with full strength: pull held at its limit
        load_setup(32'h0000_0001, 32'd0, 32'h0FFF_FFFF, 32'd0, 32'd0,
                   32'd0, 32'd0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);

        // zero strength, moving particle
        load_setup(32'd0, 32'd0, 32'd0, 32'h0010_0000, 32'hFFF0_0000,
                   32'hFFFF_8000, 32'h0000_8000);
        send_item(1'b1);
        send_item(1'b0);

        // random setups, each opening with a restart and then mostly ticks
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sx = pick_coord();
            sy = pick_coord();
            if ($urandom_range(0, 7) == 0)
                load_setup(sx, sy, pick_strength(), sx, sy, pick_speed(), pick_speed());
            else
                load_setup(sx, sy, pick_strength(), pick_coord(), pick_coord(),
                           pick_speed(), pick_speed());
            send_item(1'b1);
            sent++;
            repeat ($urandom_range(40, 90)) begin
                send_item($urandom_range(0, 15) == 0);
                sent++;
                burst = $urandom_range(0, 3);
                if (burst == 0)
                    send_gap();
            end
        end

        // back to the reset values of every register
        load_setup(RST_SOURCE_X, RST_SOURCE_Y, RST_STRENGTH, RST_START_PX,
                   RST_START_PY, RST_START_VX, RST_START_VY);
        send_item(1'b1);
        send_item(1'b0);
        drain();
        repeat (20) @(negedge clk);

        $display("covered %0d result beats (%0d restarts, %0d saturated), %0d register writes",
                 results_seen, restarts_seen, sat_seen, cfg_writes);
        $display("setups: extremes, zero distance, held pull, zero strength, random orbits");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/isg_pkg.sv
src/isg_mul.sv
src/isg_sqrt.sv
src/isg_div.sv
src/inverse_square_gravity_step_core.sv
dv/isg_checker.sv
dv/tb_top.sv
